### rtl/core/assembly_source_tokenizer_assert.svh
// assertion macros for the assembly source tokenizer
`ifndef ASSEMBLY_SOURCE_TOKENIZER_ASSERT_SVH
`define ASSEMBLY_SOURCE_TOKENIZER_ASSERT_SVH

// same-cycle implication, off during reset
`define ASMT_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, off during reset
`define ASMT_ASSERT_NXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/asmt_pkg.sv
// shared types, constants and mnemonic table of the tokenizer
package asmt_pkg;

	localparam int LITERAL_BITS_DEF = 32;
	localparam int MAX_IDENT_LEN    = 128;
	localparam int REG_COUNT        = 16;
	localparam int QUEUE_DEPTH      = 4;
	localparam int MNEM_COUNT       = 12;

	typedef enum logic [3:0] {
		KIND_END,
		KIND_REG,
		KIND_LIT,
		KIND_COMMA,
		KIND_LBRACK,
		KIND_RBRACK,
		KIND_LPAREN,
		KIND_RPAREN,
		KIND_PLUS,
		KIND_MINUS,
		KIND_STAR,
		KIND_SLASH,
		KIND_TILDE,
		KIND_NEWLINE,
		KIND_MNEM,
		KIND_ERR
	} kind_t;

	typedef enum logic [2:0] {
		ERR_NONE,
		ERR_UNKNOWN_CHAR,
		ERR_BAD_REG,
		ERR_TOO_LONG,
		ERR_BAD_LABEL,
		ERR_OVERFLOW
	} err_t;

	typedef enum logic [2:0] {
		MODE_IDLE,
		MODE_REG,
		MODE_LIT,
		MODE_WORD,
		MODE_DROP
	} mode_t;

	typedef struct packed {
		kind_t       kind;
		logic [3:0]  reg_num;
		logic [31:0] lit;
		logic [3:0]  op;
		logic [2:0]  places;
		err_t        err;
		logic        last;
	} tok_t;

	// one or two tokens caused by one character
	typedef struct packed {
		logic valid;
		logic pair;
		tok_t first;
		tok_t second;
	} entry_t;

	typedef struct packed {
		logic       hit;
		logic [3:0] op;
		logic [2:0] places;
	} mnem_t;

	localparam logic [23:0] MNEM_NAME [MNEM_COUNT] = '{
		24'h6c7672, 24'h616464, 24'h737562, 24'h6d756c,
		24'h646976, 24'h6c6670, 24'h6c7069, 24'h6c706f,
		24'h736c76, 24'h767473, 24'h766673, 24'h636f6d
	};

	localparam logic [2:0] MNEM_PLACES [MNEM_COUNT] = '{
		3'd3, 3'd5, 3'd5, 3'd5, 3'd5, 3'd3, 3'd3, 3'd3, 3'd3, 3'd1, 3'd1, 3'd3
	};

	// match a three-letter word against the mnemonic table
	function automatic mnem_t mnem_find(input logic [23:0] word);
		mnem_t res;
		res = '0;
		for (int i = MNEM_COUNT - 1; i >= 0; i--) begin
			if (word == MNEM_NAME[i]) begin
				res.hit    = 1'b1;
				res.op     = 4'(i);
				res.places = MNEM_PLACES[i];
			end
		end
		return res;
	endfunction

endpackage

### rtl/core/asmt_char_if.sv
// character channel: valid, ready and one source byte
interface asmt_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] source_char;

	modport source (output valid, output source_char, input ready);
	modport sink (input valid, input source_char, output ready);
endinterface

### rtl/core/asmt_tok_if.sv
// token channel: valid, ready and the token fields
interface asmt_tok_if;
	logic        valid;
	logic        ready;
	logic [3:0]  token_kind;
	logic [3:0]  register_number;
	logic [31:0] literal_value;
	logic [3:0]  opcode;
	logic [2:0]  syntax_length;
	logic [2:0]  error_code;
	logic        last;

	modport source (output valid, output token_kind, output register_number,
		output literal_value, output opcode, output syntax_length, output error_code,
		output last, input ready);
	modport sink (input valid, input token_kind, input register_number,
		input literal_value, input opcode, input syntax_length, input error_code,
		input last, output ready);
endinterface

### rtl/core/asmt_front.sv
// front end: takes characters, runs the lexer modes and builds token pairs
module asmt_front import asmt_pkg::*; #(
	parameter int LITERAL_BITS = LITERAL_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	asmt_char_if.sink   src,
	input  logic        room,
	output entry_t      push
);

	localparam int LW = (LITERAL_BITS < 32) ? LITERAL_BITS : 32;

	mode_t                   mode_q, mode_d, mode_a;
	logic [LITERAL_BITS-1:0] acc_q, acc_d;
	logic [23:0]             prefix_q, prefix_d;
	logic [7:0]              len_q, len_d;
	logic                    ovf_q, ovf_d;

	logic [7:0]              c;
	logic                    accept, alpha, digit, wordch;
	logic [LITERAL_BITS+3:0] prod;
	logic [4:0]              reg_idx;
	logic                    reg_ok;
	mnem_t                   mn;
	tok_t                    tok_a, tok_b;
	logic                    emit_a, emit_b, done;

	assign c         = src.source_char;
	assign src.ready = room;
	assign accept    = src.valid & room;
	assign alpha     = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	assign digit     = (c >= "0" && c <= "9");
	assign wordch    = alpha || digit || (c == "_");

	// times ten plus the digit, with room to see overflow
	assign prod = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1)
		+ {{LITERAL_BITS{1'b0}}, c[3:0]};

	assign mn = mnem_find(prefix_q);

	// register name check
	always_comb begin
		reg_ok  = 1'b0;
		reg_idx = '0;
		if (len_q == 8'd2 && prefix_q[15:8] == "r"
			&& prefix_q[7:0] >= "0" && prefix_q[7:0] <= "9") begin
			reg_ok  = 1'b1;
			reg_idx = {1'b0, prefix_q[3:0]};
		end else if (len_q == 8'd3 && prefix_q[23:16] == "r" && prefix_q[15:8] == "1"
			&& prefix_q[7:0] >= "0" && prefix_q[7:0] <= "5") begin
			reg_ok  = 1'b1;
			reg_idx = 5'd10 + {1'b0, prefix_q[3:0]};
		end
		if (reg_idx >= 5'(REG_COUNT)) begin
			reg_ok = 1'b0;
		end
	end

	// lexer next state and tokens
	always_comb begin
		mode_a   = mode_q;
		mode_d   = mode_q;
		acc_d    = acc_q;
		prefix_d = prefix_q;
		len_d    = len_q;
		ovf_d    = ovf_q;
		tok_a    = '0;
		tok_b    = '0;
		emit_a   = 1'b0;
		emit_b   = 1'b0;
		done     = 1'b0;

		// finish or extend the token in progress
		unique case (mode_q)
			MODE_LIT: begin
				if (digit) begin
					done = 1'b1;
					if (ovf_q || prod[LITERAL_BITS+3:LITERAL_BITS] != 4'd0) begin
						ovf_d = 1'b1;
						acc_d = '1;
					end else begin
						acc_d = prod[LITERAL_BITS-1:0];
					end
				end else begin
					emit_a     = 1'b1;
					tok_a.kind = KIND_LIT;
					tok_a.lit  = 32'(acc_q[LW-1:0]);
					tok_a.err  = ovf_q ? ERR_OVERFLOW : ERR_NONE;
					mode_a     = MODE_IDLE;
				end
			end
			MODE_REG: begin
				if (alpha || digit) begin
					done = 1'b1;
					if (len_q < 8'd3) prefix_d = {prefix_q[15:0], c};
					if (len_q != 8'hff) len_d = len_q + 8'd1;
				end else if (reg_ok) begin
					emit_a        = 1'b1;
					tok_a.kind    = KIND_REG;
					tok_a.reg_num = reg_idx[3:0];
					mode_a        = MODE_IDLE;
				end else begin
					emit_a     = 1'b1;
					tok_a.kind = KIND_ERR;
					tok_a.err  = ERR_BAD_REG;
					mode_a     = MODE_DROP;
				end
			end
			MODE_WORD: begin
				if (wordch) begin
					done = 1'b1;
					if (len_q >= 8'(MAX_IDENT_LEN - 1)) begin
						emit_a     = 1'b1;
						tok_a.kind = KIND_ERR;
						tok_a.err  = ERR_TOO_LONG;
						mode_a     = MODE_DROP;
					end else begin
						if (len_q < 8'd3) prefix_d = {prefix_q[15:0], c};
						len_d = len_q + 8'd1;
					end
				end else if (len_q == 8'd3 && mn.hit) begin
					emit_a       = 1'b1;
					tok_a.kind   = KIND_MNEM;
					tok_a.op     = mn.op;
					tok_a.places = mn.places;
					mode_a       = MODE_IDLE;
				end else begin
					emit_a     = 1'b1;
					tok_a.kind = KIND_ERR;
					tok_a.err  = ERR_BAD_LABEL;
					mode_a     = MODE_DROP;
				end
			end
			MODE_IDLE, MODE_DROP: ;
			default: mode_a = MODE_IDLE;
		endcase

		// the character itself, unless already used above
		if (done) begin
			mode_d = mode_a;
		end else if (mode_a == MODE_DROP) begin
			mode_d = MODE_DROP;
			if (c == 8'h00) begin
				emit_b     = 1'b1;
				tok_b.kind = KIND_END;
				mode_d     = MODE_IDLE;
			end
		end else begin
			mode_d = MODE_IDLE;
			unique case (c)
				8'h20, 8'h09: ;
				8'h00: begin emit_b = 1'b1; tok_b.kind = KIND_END; end
				"%": begin
					mode_d   = MODE_REG;
					prefix_d = '0;
					len_d    = '0;
				end
				"$": begin
					mode_d = MODE_LIT;
					acc_d  = '0;
					ovf_d  = 1'b0;
				end
				",": begin emit_b = 1'b1; tok_b.kind = KIND_COMMA; end
				"[": begin emit_b = 1'b1; tok_b.kind = KIND_LBRACK; end
				"]": begin emit_b = 1'b1; tok_b.kind = KIND_RBRACK; end
				"(": begin emit_b = 1'b1; tok_b.kind = KIND_LPAREN; end
				")": begin emit_b = 1'b1; tok_b.kind = KIND_RPAREN; end
				"+": begin emit_b = 1'b1; tok_b.kind = KIND_PLUS; end
				"-": begin emit_b = 1'b1; tok_b.kind = KIND_MINUS; end
				"*": begin emit_b = 1'b1; tok_b.kind = KIND_STAR; end
				"/": begin emit_b = 1'b1; tok_b.kind = KIND_SLASH; end
				"~": begin emit_b = 1'b1; tok_b.kind = KIND_TILDE; end
				8'h0a: begin emit_b = 1'b1; tok_b.kind = KIND_NEWLINE; end
				default: begin
					if (alpha || c == "_") begin
						mode_d   = MODE_WORD;
						prefix_d = {16'b0, c};
						len_d    = 8'd1;
					end else begin
						emit_b     = 1'b1;
						tok_b.kind = KIND_ERR;
						tok_b.err  = ERR_UNKNOWN_CHAR;
						mode_d     = MODE_DROP;
					end
				end
			endcase
		end
	end

	// word toward the queue
	always_comb begin
		push             = '0;
		push.valid       = accept & (emit_a | emit_b);
		push.pair        = emit_a & emit_b;
		push.first       = emit_a ? tok_a : tok_b;
		push.first.last  = ~(emit_a & emit_b);
		push.second      = tok_b;
		push.second.last = 1'b1;
	end

	// lexer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_IDLE;
			acc_q    <= '0;
			prefix_q <= '0;
			len_q    <= '0;
			ovf_q    <= 1'b0;
		end else if (accept) begin
			mode_q   <= mode_d;
			acc_q    <= acc_d;
			prefix_q <= prefix_d;
			len_q    <= len_d;
			ovf_q    <= ovf_d;
		end
	end

endmodule

### rtl/core/asmt_queue.sv
// short queue of token pairs between front and back end
module asmt_queue import asmt_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  entry_t push,
	input  logic   pop,
	output logic   room,
	output entry_t head
);

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	entry_t          mem_q [QUEUE_DEPTH];
	logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push, do_pop;

	assign room    = (count_q != CW'(QUEUE_DEPTH));
	assign do_push = push.valid & room;
	assign do_pop  = pop & (count_q != '0);

	// head word
	always_comb begin
		head       = mem_q[rd_ptr_q];
		head.valid = (count_q != '0);
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push;
		end
	end

endmodule

### rtl/core/asmt_back.sv
// back end: splits token pairs and drives the output register
module asmt_back import asmt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  entry_t      head,
	output logic        pop,
	asmt_tok_if.source  tok
);

	logic out_valid_q, pend_valid_q;
	tok_t out_q, pend_q;
	logic take;

	assign take = ~out_valid_q | tok.ready;
	assign pop  = head.valid & ~pend_valid_q & take;

	// output fields
	assign tok.valid           = out_valid_q;
	assign tok.token_kind      = out_q.kind;
	assign tok.register_number = out_q.reg_num;
	assign tok.literal_value   = out_q.lit;
	assign tok.opcode          = out_q.op;
	assign tok.syntax_length   = out_q.places;
	assign tok.error_code      = out_q.err;
	assign tok.last            = out_q.last;

	// output and pending valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			pend_valid_q <= 1'b0;
		end else if (take) begin
			if (pend_valid_q) begin
				out_valid_q  <= 1'b1;
				pend_valid_q <= 1'b0;
			end else if (head.valid) begin
				out_valid_q  <= 1'b1;
				pend_valid_q <= head.pair;
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// token payload
	always_ff @(posedge clk) begin
		if (take) begin
			if (pend_valid_q) begin
				out_q <= pend_q;
			end else if (head.valid) begin
				out_q  <= head.first;
				pend_q <= head.second;
			end
		end
	end

endmodule

### rtl/core/assembly_source_tokenizer.sv
// top level of the assembly source tokenizer
// Takes one source byte per word on src and gives tokens on tok. A byte is
// accepted in every cycle while the four-entry pair queue between the lexer
// front end and the output back end has room; the output delivers one token
// word per cycle while tok.ready is high, so a byte that both closes a register,
// literal or word and starts a punctuation or end token yields two output
// words, and a byte that only extends a token, or a blank between tokens, yields
// none. A token reaches tok through the queue storage and the back-end output
// register. Literals are accumulated to LITERAL_BITS bits with a shift-and-add
// times ten; after an error token all bytes up to the next zero byte are dropped.
`include "assembly_source_tokenizer_assert.svh"

module assembly_source_tokenizer import asmt_pkg::*; #(
	parameter int LITERAL_BITS = LITERAL_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	asmt_char_if.sink  src,
	asmt_tok_if.source tok
);

	entry_t fr_push;
	entry_t q_head;
	logic   q_room;
	logic   bk_pop;

	// lexer front end
	asmt_front #(
		.LITERAL_BITS(LITERAL_BITS)
	) u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.src   (src),
		.room  (q_room),
		.push  (fr_push)
	);

	// pair queue
	asmt_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (fr_push),
		.pop   (bk_pop),
		.room  (q_room),
		.head  (q_head)
	);

	// output back end
	asmt_back u_back (
		.clk   (clk),
		.arst_n(arst_n),
		.head  (q_head),
		.pop   (bk_pop),
		.tok   (tok)
	);

	// checks
	`ASMT_ASSERT_IMP(a_push_has_room, fr_push.valid, q_room, "token pair pushed into a full queue")
	`ASMT_ASSERT_NXT(a_pair_follows, tok.valid && tok.ready && !tok.last, tok.valid, "second token of a pair missing")
	`ASMT_ASSERT_IMP(a_mnem_places, tok.valid && tok.token_kind == KIND_MNEM, tok.syntax_length != 3'd0, "mnemonic token without syntax places")

endmodule
